// ===== src/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic spline evaluator package
// Shared types and fixed widths for the spline evaluator blocks.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int OUT_W = 32;   // Q16.16 field width
    localparam int ACC_W = 48;   // Horner accumulator width
    localparam int DX_W  = 33;   // exact offset from knot
    localparam int HALF_W = ACC_W / 2;
    localparam int PP_W  = HALF_W + DX_W;
    localparam int PROD_W = ACC_W + DX_W;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] KNOT_COUNT_RESET = 7'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_VALUE  = 2'd1,
        FN_DERIV1 = 2'd2,
        FN_DERIV2 = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [5:0]         entry_index;
        logic signed [31:0] knot_pos;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] query_pos;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               out_of_range;
        logic               saturated;
        logic [5:0]         segment;
    } t_out_item;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_ABS,
        MUL_LO,
        MUL_HI,
        MUL_RND
    } t_mul_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BOUND0,
        S_BOUND1,
        S_SEARCH,
        S_FETCH,
        S_ABS,
        S_LO,
        S_HI,
        S_RND,
        S_ADD,
        S_FIN
    } t_state;

endpackage

// ===== src/cse_ram.sv =====
// ----------------------------------------------------------------------------
// Spline table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cse_mulq.sv =====
// ----------------------------------------------------------------------------
// Fixed point multiplier
// Sign-magnitude 48x33 multiply in two halves, round and saturate to 48 bits.
// ----------------------------------------------------------------------------
module cse_mulq
    import cse_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  t_mul_op                 i_op,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [DX_W-1:0]  i_dx,
    output logic signed [ACC_W-1:0] o_prod,
    output logic                    o_sat
);

    logic              r_neg;
    logic [ACC_W-1:0]  r_ma;
    logic [DX_W-1:0]   r_mb;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_res;
    logic              r_sat;

    logic [HALF_W-1:0] mul_a;
    logic [PP_W-1:0]   pp;
    logic [PROD_W:0]   rnd_sum;
    logic [PROD_W:0]   mag;
    logic [PROD_W:0]   lim;

    always_comb begin
        mul_a   = (i_op == MUL_HI) ? r_ma[ACC_W-1:HALF_W] : r_ma[HALF_W-1:0];
        pp      = mul_a * r_mb;
        rnd_sum = {1'b0, r_prod} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
        mag     = rnd_sum >> FRAC_BITS;
        lim     = r_neg ? (PROD_W+1)'(ACC_MAX) + (PROD_W+1)'(1) : (PROD_W+1)'(ACC_MAX);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            MUL_ABS: begin
                r_neg <= i_acc[ACC_W-1] ^ i_dx[DX_W-1];
                r_ma  <= i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
                r_mb  <= i_dx[DX_W-1] ? DX_W'(-i_dx) : DX_W'(i_dx);
            end
            MUL_LO: begin
                r_prod <= PROD_W'(pp);
            end
            MUL_HI: begin
                r_prod <= r_prod + {pp, {HALF_W{1'b0}}};
            end
            MUL_RND: begin
                if (mag > lim) begin
                    r_sat <= 1'b1;
                    r_res <= r_neg ? ACC_MIN : ACC_MAX;
                end else begin
                    r_sat <= 1'b0;
                    r_res <= r_neg ? ACC_W'(-mag[ACC_W-1:0]) : mag[ACC_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_prod = r_res;
    assign o_sat  = r_sat;

endmodule

// ===== src/cubic_spline_evaluator.sv =====
// ----------------------------------------------------------------------------
// Cubic spline evaluator
// Knot table in RAM, binary segment search, Horner evaluation in Q16.16.
// ----------------------------------------------------------------------------
// Load items are written while idle; busy stays low and the next item may follow.
// Queries read the two bounds, search with one read per halving, fetch the
// segment entry, then run 3/2/1 Horner steps (value, first, second derivative)
// through ABS, LO, HI, RND and ADD, and clip in a final state. The knot RAM
// read port and the shared two-pass multiplier set the query length. Result strobe is one cycle, no stall.
// Synchronous active-low reset clears control and sets knot_count to 2;
// table contents are undefined until loaded.
module cubic_spline_evaluator
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_result_valid,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int CNT_W = $clog2(MAX_KNOTS + 1);
    localparam int COEF_W = 4 * OUT_W;

    // Control state
    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_knot_count;
    logic             r_out_valid, n_out_valid;

    // Query payload
    t_func                   r_func;
    logic signed [OUT_W-1:0] r_t;
    logic [CNT_W-1:0]        r_n;
    logic signed [OUT_W-1:0] r_x0;
    logic [CNT_W-1:0]        r_lo, r_hi;
    logic [IDX_W-1:0]        r_mid, r_seg;
    logic signed [DX_W-1:0]  r_dx;
    logic signed [OUT_W-1:0] r_ca, r_cb, r_cc;
    logic signed [ACC_W-1:0] r_acc;
    logic [1:0]              r_step;
    logic                    r_sat;
    t_out_item               r_out;

    // RAM ports
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        rd_addr;
    logic [OUT_W-1:0]        knot_rdata;
    logic [COEF_W-1:0]       coef_rdata;
    logic signed [OUT_W-1:0] knot_q;

    // Multiplier
    t_mul_op                 mul_op;
    logic signed [ACC_W-1:0] mul_prod;
    logic                    mul_sat;

    // Datapath helpers
    logic             accept;
    logic [CNT_W-1:0] n_clamp;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] n_lo, n_hi;
    logic [IDX_W-1:0] n_mid;
    logic [IDX_W-1:0] seg_pick;
    logic             search_done;
    logic             oor;
    logic [1:0]       last_step;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W:0]   sum_full;
    logic signed [ACC_W-1:0] sum_clip;
    logic                    sum_ovf;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign knot_q      = $signed(knot_rdata);

    // Write the whole entry on a load; drop loads beyond the table.
    assign ram_we    = accept && (i_item.func == FN_LOAD)
                       && (32'(i_item.entry_index) < MAX_KNOTS);
    assign ram_waddr = IDX_W'(32'(i_item.entry_index));

    cse_ram #(.WIDTH(OUT_W), .DEPTH(MAX_KNOTS)) u_knot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.knot_pos),
        .i_raddr (rd_addr),
        .o_rdata (knot_rdata)
    );

    cse_ram #(.WIDTH(COEF_W), .DEPTH(MAX_KNOTS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_item.coef_d, i_item.coef_c, i_item.coef_b, i_item.coef_a}),
        .i_raddr (rd_addr),
        .o_rdata (coef_rdata)
    );

    cse_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .i_acc  (r_acc),
        .i_dx   (r_dx),
        .o_prod (mul_prod),
        .o_sat  (mul_sat)
    );

    // Search and Horner helpers
    always_comb begin
        // Clamp knot count to [2, MAX_KNOTS]
        if (r_knot_count < CFG_W'(2)) begin
            n_clamp = CNT_W'(2);
        end else if (32'(r_knot_count) > MAX_KNOTS) begin
            n_clamp = CNT_W'(MAX_KNOTS);
        end else begin
            n_clamp = CNT_W'(r_knot_count);
        end

        oor = ($signed(r_t) < r_x0) || ($signed(r_t) > knot_q);

        // Halve the range around the knot just read
        search_done = (r_t == knot_q) || ((r_hi - r_lo) <= CNT_W'(1));
        if (r_t > knot_q) begin
            n_lo = CNT_W'(r_mid);
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = CNT_W'(r_mid);
        end
        mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
        n_mid   = IDX_W'(mid_sum >> 1);

        // Clamp to the last segment
        if (CNT_W'(r_mid) > (r_n - CNT_W'(2))) begin
            seg_pick = IDX_W'(r_n - CNT_W'(2));
        end else begin
            seg_pick = r_mid;
        end

        unique case (r_func)
            FN_VALUE:  last_step = 2'd2;
            FN_DERIV1: last_step = 2'd1;
            default:   last_step = 2'd0;
        endcase

        unique case (r_step)
            2'd0: begin
                if (r_func == FN_VALUE) begin
                    addend = ACC_W'(r_cc);
                end else begin
                    addend = ACC_W'(r_cc) <<< 1;
                end
            end
            2'd1:    addend = ACC_W'(r_cb);
            default: addend = ACC_W'(r_ca);
        endcase

        sum_full = (ACC_W+1)'(addend) + (ACC_W+1)'(mul_prod);
        sum_ovf  = sum_full[ACC_W] != sum_full[ACC_W-1];
        if (sum_ovf) begin
            sum_clip = sum_full[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_clip = sum_full[ACC_W-1:0];
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_knot_count <= KNOT_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_knot_count <= i_cfg_data;
            end
        end
    end

    // Next state, RAM read address, multiplier command
    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        rd_addr     = '0;
        mul_op      = MUL_IDLE;
        busy        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (accept && (i_item.func != FN_LOAD)) begin
                    n_state = S_BOUND0;
                end
            end
            S_BOUND0: begin
                rd_addr = IDX_W'(r_n - CNT_W'(1));
                n_state = S_BOUND1;
            end
            S_BOUND1: begin
                if (oor) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    rd_addr = IDX_W'(r_n >> 1);
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (search_done) begin
                    rd_addr = seg_pick;
                    n_state = S_FETCH;
                end else begin
                    rd_addr = n_mid;
                end
            end
            S_FETCH: n_state = S_ABS;
            S_ABS: begin
                mul_op  = MUL_ABS;
                n_state = S_LO;
            end
            S_LO: begin
                mul_op  = MUL_LO;
                n_state = S_HI;
            end
            S_HI: begin
                mul_op  = MUL_HI;
                n_state = S_RND;
            end
            S_RND: begin
                mul_op  = MUL_RND;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_step == last_step) ? S_FIN : S_ABS;
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Query datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_func <= i_item.func;
                r_t    <= i_item.query_pos;
                r_n    <= n_clamp;
            end
            S_BOUND0: begin
                r_x0 <= knot_q;
            end
            S_BOUND1: begin
                r_lo  <= '0;
                r_hi  <= r_n;
                r_mid <= IDX_W'(r_n >> 1);
                r_out <= '{result_value: '0, out_of_range: 1'b1,
                           saturated: 1'b0, segment: '0};
            end
            S_SEARCH: begin
                if (search_done) begin
                    r_seg <= seg_pick;
                end else begin
                    r_lo  <= n_lo;
                    r_hi  <= n_hi;
                    r_mid <= n_mid;
                end
            end
            S_FETCH: begin
                // Offset from the segment's knot; seed the Horner chain
                r_dx   <= {r_t[OUT_W-1], r_t} - {knot_q[OUT_W-1], knot_q};
                r_ca   <= coef_rdata[OUT_W-1:0];
                r_cb   <= coef_rdata[2*OUT_W-1:OUT_W];
                r_cc   <= coef_rdata[3*OUT_W-1:2*OUT_W];
                r_step <= 2'd0;
                r_sat  <= 1'b0;
                unique case (r_func)
                    FN_VALUE:  r_acc <= ACC_W'($signed(coef_rdata[COEF_W-1:3*OUT_W]));
                    FN_DERIV1: r_acc <= ACC_W'($signed(coef_rdata[COEF_W-1:3*OUT_W])) * 3;
                    default:   r_acc <= ACC_W'($signed(coef_rdata[COEF_W-1:3*OUT_W])) * 6;
                endcase
            end
            S_ADD: begin
                r_acc  <= sum_clip;
                r_sat  <= r_sat | mul_sat | sum_ovf;
                r_step <= r_step + 2'd1;
            end
            S_FIN: begin
                // Clip the accumulator to the output range
                r_out.out_of_range <= 1'b0;
                r_out.segment      <= 6'(32'(r_seg));
                if (r_acc > ACC_W'(OUT_MAX)) begin
                    r_out.result_value <= OUT_MAX;
                    r_out.saturated    <= 1'b1;
                end else if (r_acc < ACC_W'(OUT_MIN)) begin
                    r_out.result_value <= OUT_MIN;
                    r_out.saturated    <= 1'b1;
                end else begin
                    r_out.result_value <= r_acc[OUT_W-1:0];
                    r_out.saturated    <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef NO_ASSERTIONS
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_FIN || $past(r_state) == S_BOUND1))
        else $error("result strobe without finishing state");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.out_of_range) |->
            (o_result.result_value == '0 && !o_result.saturated
             && o_result.segment == '0))
        else $error("out of range result carries data");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func != FN_LOAD) |=> busy)
        else $error("query accepted but block not busy");
`endif

endmodule

// ===== test/cse_checker.sv =====
// ----------------------------------------------------------------------------
// Cubic spline evaluator checker
// Watches the item, result and config channels, predicts each query result
// from its own copy of the knot table and compares field by field.
// ----------------------------------------------------------------------------
module cse_checker
    import cse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_in_item         i_item,
    input  logic             o_result_valid,
    input  t_out_item        o_result,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKNOTS = 64;
    localparam int FRAC   = 16;

    longint knot_x [NKNOTS];
    longint coef_a [NKNOTS];
    longint coef_b [NKNOTS];
    longint coef_c [NKNOTS];
    longint coef_d [NKNOTS];
    logic [CFG_W-1:0] knot_count = KNOT_COUNT_RESET;
    t_out_item spline_results [$];
    int errors = 0;

    assign o_errors  = errors;
    assign o_pending = spline_results.size();

    function automatic longint clip(longint v, longint lo, longint hi, inout bit sat);
        if (v > hi) begin
            sat = 1;
            return hi;
        end
        if (v < lo) begin
            sat = 1;
            return lo;
        end
        return v;
    endfunction

    // Exact product, rounded half away from zero, clipped to the accumulator.
    function automatic longint mul_round(longint p, longint q, inout bit sat);
        logic [127:0] mag;
        logic [127:0] ap;
        logic [127:0] aq;
        bit neg;
        neg = (p < 0) != (q < 0);
        ap = (p < 0) ? 128'(-p) : 128'(p);
        aq = (q < 0) ? 128'(-q) : 128'(q);
        mag = ((ap * aq) + (128'd1 << (FRAC - 1))) >> FRAC;
        if (neg) begin
            if (mag > (128'd1 << 47)) begin
                sat = 1;
                return longint'(ACC_MIN);
            end
            return -longint'(mag[63:0]);
        end
        if (mag > ((128'd1 << 47) - 1)) begin
            sat = 1;
            return longint'(ACC_MAX);
        end
        return longint'(mag[63:0]);
    endfunction

    function automatic t_out_item eval_query(t_func fn, logic signed [31:0] pos);
        t_out_item r;
        int n;
        int lo;
        int hi;
        int mid;
        int seg;
        longint t;
        longint dx;
        longint acc;
        longint amin;
        longint amax;
        bit sat;
        amin = longint'(ACC_MIN);
        amax = longint'(ACC_MAX);
        sat = 0;
        n = knot_count;
        if (n < 2) n = 2;
        if (n > NKNOTS) n = NKNOTS;
        t = pos;
        r = '0;
        if (t < knot_x[0] || t > knot_x[n-1]) begin
            r.out_of_range = 1'b1;
            return r;
        end
        lo = 0;
        hi = n;
        forever begin
            mid = (lo + hi) / 2;
            if (t == knot_x[mid] || hi - lo <= 1) break;
            if (t > knot_x[mid]) lo = mid;
            else hi = mid;
        end
        seg = (mid > n - 2) ? n - 2 : mid;
        dx = t - knot_x[seg];
        // Take each product on its own so its clip flag sticks before the sum.
        case (fn)
            FN_VALUE: begin
                acc = coef_d[seg];
                acc = mul_round(acc, dx, sat);
                acc = clip(coef_c[seg] + acc, amin, amax, sat);
                acc = mul_round(acc, dx, sat);
                acc = clip(coef_b[seg] + acc, amin, amax, sat);
                acc = mul_round(acc, dx, sat);
                acc = clip(coef_a[seg] + acc, amin, amax, sat);
            end
            FN_DERIV1: begin
                acc = 3 * coef_d[seg];
                acc = mul_round(acc, dx, sat);
                acc = clip(2 * coef_c[seg] + acc, amin, amax, sat);
                acc = mul_round(acc, dx, sat);
                acc = clip(coef_b[seg] + acc, amin, amax, sat);
            end
            default: begin
                acc = mul_round(6 * coef_d[seg], dx, sat);
                acc = clip(2 * coef_c[seg] + acc, amin, amax, sat);
            end
        endcase
        acc = clip(acc, longint'(OUT_MIN), longint'(OUT_MAX), sat);
        r.result_value = acc[31:0];
        r.saturated = sat;
        r.segment = seg[5:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) knot_count <= i_cfg_data;
            // Results first: a query accepted at this edge cannot finish at it.
            if (o_result_valid) begin
                if (spline_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, o_result);
                    errors <= errors + 1;
                end else begin
                    want = spline_results.pop_front();
                    if (want !== o_result) begin
                        $display("%0t: mismatch expected val=%h oor=%b sat=%b seg=%0d",
                                 $realtime, want.result_value, want.out_of_range,
                                 want.saturated, want.segment);
                        $display("%0t:          actual   val=%h oor=%b sat=%b seg=%0d",
                                 $realtime, o_result.result_value, o_result.out_of_range,
                                 o_result.saturated, o_result.segment);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (i_item.func == FN_LOAD) begin
                    knot_x[i_item.entry_index] = i_item.knot_pos;
                    coef_a[i_item.entry_index] = i_item.coef_a;
                    coef_b[i_item.entry_index] = i_item.coef_b;
                    coef_c[i_item.entry_index] = i_item.coef_c;
                    coef_d[i_item.entry_index] = i_item.coef_d;
                end else begin
                    spline_results = {spline_results,
                                      eval_query(i_item.func, i_item.query_pos)};
                end
            end
        end
    end
endmodule

// ===== test/tb_cubic_spline_evaluator.sv =====
// ----------------------------------------------------------------------------
// Cubic spline evaluator testbench
// Loads knot tables, issues value and derivative queries under varying knot
// counts and sender idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cubic_spline_evaluator;
    import cse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1000000;
    localparam int DRAIN = 40;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_item         i_item = '0;
    logic             o_result_valid;
    t_out_item        o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int               errors;
    int               pending;
    int               cycles = 0;
    int               idle_pct = 0;
    longint           knot_pos_copy [64];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cubic_spline_evaluator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    cse_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: the slowest correct run stays far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[cubic_spline_evaluator] ERROR");
            $finish;
        end
    end

    // Hold the item on the port until the transfer, then idle at random.
    task automatic send(t_in_item it);
        int gap;
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain all results and let a trailing load settle before a register write.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] cnt);
        drain();
        i_cfg_data <= cnt;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Don't-care fields get random content so every bit toggles.
    function automatic t_in_item noise_item();
        t_in_item it;
        it.func = t_func'($urandom_range(3));
        it.entry_index = 6'($urandom);
        it.knot_pos = $urandom;
        it.coef_a = $urandom;
        it.coef_b = $urandom;
        it.coef_c = $urandom;
        it.coef_d = $urandom;
        it.query_pos = $urandom;
        return it;
    endfunction

    task automatic load(int idx, logic signed [31:0] x, logic signed [31:0] a,
                        logic signed [31:0] b, logic signed [31:0] c,
                        logic signed [31:0] d);
        t_in_item it;
        it = noise_item();
        it.func = FN_LOAD;
        it.entry_index = idx[5:0];
        it.knot_pos = x;
        it.coef_a = a;
        it.coef_b = b;
        it.coef_c = c;
        it.coef_d = d;
        knot_pos_copy[idx] = x;
        send(it);
    endtask

    task automatic query(t_func fn, logic signed [31:0] t);
        t_in_item it;
        it = noise_item();
        it.func = fn;
        it.query_pos = t;
        send(it);
    endtask

    function automatic logic signed [31:0] small_coef(bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(2 ** 21)) - (2 ** 20);
    endfunction

    // Sorted knot positions; small steps keep dx, and most results, moderate.
    task automatic load_sorted_table(bit wide);
        longint x;
        x = longint'($signed($urandom_range(2 ** 24))) - (2 ** 23);
        for (int i = 0; i < 64; i++) begin
            load(i, x[31:0], small_coef(wide), small_coef(wide),
                 small_coef(wide), small_coef(wide));
            x += $urandom_range(wide ? 2 ** 22 : 2 ** 18, 1);
        end
    endtask

    task automatic random_query(int n);
        int k;
        longint t;
        t_func fn;
        fn = t_func'($urandom_range(3, 1));
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: t = longint'($signed($urandom));
            1: t = knot_pos_copy[0] - $urandom_range(3, 1);
            2: t = knot_pos_copy[n-1] + $urandom_range(3, 1);
            3, 4: t = knot_pos_copy[k];
            default: begin
                t = knot_pos_copy[k];
                if (k < n - 1) t += $urandom_range(knot_pos_copy[k+1] - t);
            end
        endcase
        query(fn, t[31:0]);
    endtask

    initial begin
        int sent;
        int n;
        int round;
        logic [CFG_W-1:0] cnt;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole table so no query ever reads an unwritten entry.
        load_sorted_table(1'b0);

        // Directed: widest span at the reset count of two knots.
        load(0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             32'sh7fff_ffff);
        load(1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000);
        for (int f = 1; f < 4; f++) begin
            query(t_func'(f), 32'sh8000_0000);     // first knot
            query(t_func'(f), 32'sh7fff_ffff);     // end knot uses last segment
            query(t_func'(f), 32'sh0000_0000);
        end
        load(0, 32'sh0001_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000);
        query(FN_VALUE, 32'sh0000_ffff);           // below the first knot
        query(FN_VALUE, 32'sh7fff_ffff);
        query(FN_DERIV1, 32'sh0001_0000);
        query(FN_DERIV2, 32'sh4000_0000);
        load(1, 32'sh0001_0000, 32'sh0000_0001, 32'sh0, 32'sh0, 32'sh0);
        query(FN_VALUE, 32'sh0001_0001);           // above the end knot
        query(FN_DERIV2, 32'sh0001_0000);

        // Counts below two and above the table clamp.
        write_count(7'd0);
        load_sorted_table(1'b0);
        query(FN_VALUE, knot_pos_copy[1][31:0]);
        write_count(7'd127);
        query(FN_DERIV1, knot_pos_copy[63][31:0]);
        query(FN_VALUE, knot_pos_copy[32][31:0]);

        sent = 0;
        round = 0;
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 7 : (ph == 1) ? 51 : 0;
            repeat (6) begin
                case (round % 6)
                    0: cnt = 7'd2;
                    1: cnt = 7'd64;
                    2: cnt = 7'd1;
                    3: cnt = 7'd100;
                    default: cnt = $urandom_range(64, 2);
                endcase
                write_count(cnt);
                n = (cnt < 2) ? 2 : (cnt > 64) ? 64 : cnt;
                if (round % 3 == 0) begin
                    load_sorted_table(round % 6 == 3);
                    sent += 64;
                end else begin
                    // Rewrite coefficients in place, and now and then a knot
                    // position at random to exercise an unsorted table.
                    repeat (12) begin
                        int e;
                        e = $urandom_range(63);
                        load(e, ($urandom_range(9) == 0) ? $urandom :
                             knot_pos_copy[e][31:0], small_coef($urandom_range(3) == 0),
                             small_coef(0), small_coef(0), small_coef($urandom_range(4) == 0));
                    end
                    sent += 12;
                end
                repeat (20) begin
                    random_query(n);
                end
                sent += 20;
                round++;
            end
            // Keep going until this phase has carried its share.
            while (sent < (ph + 1) * 540) begin
                if ($urandom_range(7) == 0) begin
                    int e;
                    e = $urandom_range(63);
                    load(e, knot_pos_copy[e][31:0], small_coef(0), small_coef(0),
                         small_coef(0), small_coef(1));
                end else begin
                    random_query(n);
                end
                sent++;
            end
        end

        drain();
        if (errors == 0) begin
            $display("[cubic_spline_evaluator] OK");
        end else begin
            $display("[cubic_spline_evaluator] ERROR");
        end
        $finish;
    end
endmodule
